// File: rtl/aoi_pkg.sv
package aoi_pkg;

	localparam int AOI_CORDIC_STEPS = 24;
	localparam int AOI_MW = 34;
	localparam int AOI_DW = 64;
	localparam int AOI_AW = 3;

	localparam logic AOI_REG_RATE = 1'b0;
	localparam logic AOI_REG_GAIN = 1'b1;

	localparam logic signed [AOI_MW-1:0] AOI_CORDIC_START = 34'sd652032874;
	localparam logic signed [AOI_MW-1:0] AOI_ONE_Q30 = 34'sd1073741824;
	localparam logic signed [AOI_MW-1:0] AOI_INV_TURN = 34'sd683565276;
	localparam logic signed [41:0] AOI_STRAIGHT_LIM = 42'sd4294967;
	localparam logic signed [23:0] AOI_SPEED_LIM = 24'sd65;

	function automatic logic signed [AOI_MW-1:0] aoi_atan(input logic [4:0] idx);
		logic signed [AOI_MW-1:0] v;
		case (idx)
			5'd0: v = 34'sd536870912;
			5'd1: v = 34'sd316933406;
			5'd2: v = 34'sd167458907;
			5'd3: v = 34'sd85004756;
			5'd4: v = 34'sd42667331;
			5'd5: v = 34'sd21354465;
			5'd6: v = 34'sd10679838;
			5'd7: v = 34'sd5340245;
			5'd8: v = 34'sd2670163;
			5'd9: v = 34'sd1335087;
			5'd10: v = 34'sd667544;
			5'd11: v = 34'sd333772;
			5'd12: v = 34'sd166886;
			5'd13: v = 34'sd83443;
			5'd14: v = 34'sd41722;
			5'd15: v = 34'sd20861;
			5'd16: v = 34'sd10430;
			5'd17: v = 34'sd5215;
			5'd18: v = 34'sd2608;
			5'd19: v = 34'sd1304;
			5'd20: v = 34'sd652;
			5'd21: v = 34'sd326;
			5'd22: v = 34'sd163;
			5'd23: v = 34'sd81;
			5'd24: v = 34'sd41;
			5'd25: v = 34'sd20;
			5'd26: v = 34'sd10;
			5'd27: v = 34'sd5;
			5'd28: v = 34'sd3;
			5'd29: v = 34'sd1;
			5'd30: v = 34'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/aoi_mul.sv
module aoi_mul import aoi_pkg::*; (
	input  logic                           clk,
	input  logic signed [AOI_MW-1:0]       a,
	input  logic signed [AOI_MW-1:0]       b,
	output logic signed [2*AOI_MW-1:0]     p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// File: rtl/aoi_div.sv
module aoi_div import aoi_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [AOI_DW-1:0] dividend,
	input  logic signed [AOI_DW-1:0] divisor,
	output logic                     done,
	output logic signed [AOI_DW-1:0] quot
);

	localparam int CW = $clog2(AOI_DW);

	logic [AOI_DW-1:0] rem_q;
	logic [AOI_DW-1:0] quo_q;
	logic [AOI_DW-1:0] dvs_q;
	logic              neg_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [AOI_DW:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[AOI_DW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(AOI_DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[AOI_DW-1] ? -dividend : dividend;
			dvs_q <= divisor[AOI_DW-1] ? -divisor : divisor;
			neg_q <= dividend[AOI_DW-1] ^ divisor[AOI_DW-1];
		end else if (busy_q) begin
			rem_q <= fits ? AOI_DW'(trial - {1'b0, dvs_q}) : trial[AOI_DW-1:0];
			quo_q <= {quo_q[AOI_DW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -quo_q : quo_q;

endmodule

// File: rtl/aoi_cordic.sv
module aoi_cordic import aoi_pkg::*; #(
	parameter int CORDIC_STEPS = AOI_CORDIC_STEPS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [31:0]              angle,
	output logic                     done,
	output logic signed [AOI_MW-1:0] sin_v,
	output logic signed [AOI_MW-1:0] cos_v
);

	localparam int CW = $clog2(CORDIC_STEPS);

	logic signed [AOI_MW-1:0] x_q;
	logic signed [AOI_MW-1:0] y_q;
	logic signed [AOI_MW-1:0] z_q;
	logic                     flip_q;
	logic [CW-1:0]            cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [4:0]               idx;
	logic signed [AOI_MW-1:0] xs;
	logic signed [AOI_MW-1:0] ys;
	logic signed [AOI_MW-1:0] at;
	logic                     flip;
	logic [31:0]              fa;

	assign idx  = 5'(cnt_q);
	assign xs   = x_q >>> idx;
	assign ys   = y_q >>> idx;
	assign at   = aoi_atan(idx);
	assign flip = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
	assign fa   = flip ? (angle ^ 32'h8000_0000) : angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= AOI_CORDIC_START;
			y_q    <= '0;
			z_q    <= {{2{fa[31]}}, fa};
			flip_q <= flip;
		end else if (busy_q) begin
			if (!z_q[AOI_MW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done  = done_q;
	assign sin_v = flip_q ? -y_q : y_q;
	assign cos_v = flip_q ? -x_q : x_q;

endmodule

// File: rtl/arc_odometry_integrator.sv
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   kind, delta, desired_effort, speed
// output    out        out_valid / out_stall x_pos, y_pos, heading, steer_effort
// config    in         APB write/read        max_steer_rate, curvature_gain
//
// A transaction on an arc takes longer than one on a straight path, since there the
// 64-step divider runs twice; a distance step above the speed limit adds a time
// division. The input is taken again in the same cycle as the result is presented.
// Reset clears position, heading, effort and the registers to their defaults.
// A finished result waits in the output registers; the next transaction is taken
// meanwhile but does not update the position until the waiting result is taken.
module arc_odometry_integrator import aoi_pkg::*; #(
	parameter int CORDIC_STEPS = AOI_CORDIC_STEPS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AOI_AW-1:0]    paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 kind,
	input  logic [23:0]          delta,
	input  logic signed [15:0]   desired_effort,
	input  logic signed [23:0]   speed,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   x_pos,
	output logic signed [31:0]   y_pos,
	output logic [31:0]          heading,
	output logic signed [15:0]   steer_effort
);

	typedef enum logic [27:0] {
		ST_IDLE = 28'h0000001,
		ST_DIST = 28'h0000002,
		ST_DT   = 28'h0000004,
		ST_DTW  = 28'h0000008,
		ST_SA   = 28'h0000010,
		ST_SB   = 28'h0000020,
		ST_SC   = 28'h0000040,
		ST_KQ   = 28'h0000080,
		ST_KQC  = 28'h0000100,
		ST_M1   = 28'h0000200,
		ST_M2   = 28'h0000400,
		ST_M3   = 28'h0000800,
		ST_R1   = 28'h0001000,
		ST_R2   = 28'h0002000,
		ST_R3   = 28'h0004000,
		ST_CS0  = 28'h0008000,
		ST_L1   = 28'h0010000,
		ST_L2   = 28'h0020000,
		ST_L3   = 28'h0040000,
		ST_CS1  = 28'h0080000,
		ST_A1   = 28'h0100000,
		ST_A2   = 28'h0200000,
		ST_A3   = 28'h0400000,
		ST_A4   = 28'h0800000,
		ST_A5   = 28'h1000000,
		ST_A6   = 28'h2000000,
		ST_A7   = 28'h4000000,
		ST_UPD  = 28'h8000000
	} state_t;

	state_t state_q;

	logic [23:0]               rate_q;
	logic [23:0]               gain_q;
	logic signed [31:0]        east_q;
	logic signed [31:0]        north_q;
	logic [31:0]               yaw_q;
	logic signed [15:0]        eff_q;
	logic                      out_valid_q;

	logic                      kind_q;
	logic [23:0]               delta_q;
	logic signed [15:0]        want_q;
	logic signed [23:0]        speed_q;
	logic signed [31:0]        dist_q;
	logic [39:0]               dt_q;
	logic [40:0]               pa_q;
	logic signed [15:0]        eff_new_q;
	logic signed [41:0]        kq_q;
	logic [63:0]               m1_q;
	logic [63:0]               r_q;
	logic [31:0]               pl_q;
	logic [31:0]               dba_q;
	logic signed [AOI_MW-1:0]  s0_q;
	logic signed [AOI_MW-1:0]  c0_q;
	logic signed [AOI_MW-1:0]  sd_q;
	logic signed [AOI_MW-1:0]  cd_q;
	logic signed [63:0]        t_q;
	logic signed [63:0]        nx_q;
	logic signed [63:0]        ny_q;
	logic signed [63:0]        dx_q;
	logic signed [63:0]        dy_q;

	logic signed [AOI_MW-1:0]   mul_a;
	logic signed [AOI_MW-1:0]   mul_b;
	logic signed [2*AOI_MW-1:0] p;

	logic                       div_start;
	logic signed [AOI_DW-1:0]   div_nd;
	logic signed [AOI_DW-1:0]   div_dd;
	logic                       div_done;
	logic signed [AOI_DW-1:0]   div_q;

	logic                       cor_start;
	logic [31:0]                cor_angle;
	logic                       cor_done;
	logic signed [AOI_MW-1:0]   cor_s;
	logic signed [AOI_MW-1:0]   cor_c;

	logic                       fast;
	logic                       accept;
	logic                       wr;
	logic                       out_free;
	logic signed [16:0]         esum;
	logic [31:0]                md;
	logic [41:0]                mk;
	logic                       straight;
	logic signed [AOI_MW-1:0]   omc;
	logic signed [63:0]         den;
	logic [41:0]                lim;
	logic                       cap;
	logic signed [16:0]         mlim;
	logic signed [16:0]         dd;
	logic signed [16:0]         diff;
	logic signed [16:0]         eff_slew;
	logic [63:0]                m_sum;

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [63:0] d);
		logic signed [64:0] s;
		s = {{33{a[31]}}, a} + {d[63], d};
		if (s[64:31] == {34{s[64]}}) begin
			return s[31:0];
		end else if (s[64]) begin
			return 32'sh8000_0000;
		end else begin
			return 32'sh7fff_ffff;
		end
	endfunction

	assign pready   = 1'b1;
	assign wr       = psel && penable && pwrite;
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign fast     = speed_q > AOI_SPEED_LIM;
	assign esum     = {eff_q[15], eff_q} + {eff_new_q[15], eff_new_q};
	assign md       = dist_q[31] ? 32'(-dist_q) : 32'(dist_q);
	assign mk       = kq_q[41] ? 42'(-kq_q) : 42'(kq_q);
	assign straight = (kq_q <= AOI_STRAIGHT_LIM) && (kq_q >= -AOI_STRAIGHT_LIM);
	assign omc      = AOI_ONE_Q30 - cd_q;
	assign den      = {{10{kq_q[41]}}, kq_q, 12'b0};

	assign lim  = {1'b0, p[40:0]} + {18'b0, pa_q[40:17]};
	assign cap  = ((dt_q[39:33] != '0) && (rate_q != '0)) || (lim > 42'd65535);
	assign mlim = cap ? 17'sd65535 : {1'b0, lim[15:0]};
	assign diff = {want_q[15], want_q} - {eff_q[15], eff_q};
	assign dd   = (diff > mlim) ? mlim : ((diff < -mlim) ? -mlim : diff);
	assign eff_slew = {eff_q[15], eff_q} + dd;
	assign m_sum = m1_q + {32'b0, p[47:16]};

	always_comb begin
		prdata = '0;
		case (paddr[2])
			AOI_REG_RATE: prdata = {8'b0, rate_q};
			AOI_REG_GAIN: prdata = {8'b0, gain_q};
			default:      prdata = '0;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_DIST: begin
				mul_a = {{10{speed_q[23]}}, speed_q};
				mul_b = {10'b0, delta_q};
			end
			ST_SA: begin
				mul_a = {10'b0, rate_q};
				mul_b = {17'b0, dt_q[16:0]};
			end
			ST_SB: begin
				mul_a = {10'b0, rate_q};
				mul_b = {18'b0, dt_q[32:17]};
			end
			ST_KQ: begin
				mul_a = {{17{esum[16]}}, esum};
				mul_b = {10'b0, gain_q};
			end
			ST_M1: begin
				mul_a = {2'b0, md};
				mul_b = {8'b0, mk[41:16]};
			end
			ST_M2: begin
				mul_a = {2'b0, md};
				mul_b = {18'b0, mk[15:0]};
			end
			ST_R1: begin
				mul_a = {2'b0, r_q[31:0]};
				mul_b = AOI_INV_TURN;
			end
			ST_R2: begin
				mul_a = {2'b0, r_q[63:32]};
				mul_b = AOI_INV_TURN;
			end
			ST_L1: begin
				mul_a = s0_q;
				mul_b = {{2{dist_q[31]}}, dist_q};
			end
			ST_L2: begin
				mul_a = c0_q;
				mul_b = {{2{dist_q[31]}}, dist_q};
			end
			ST_A1: begin
				mul_a = c0_q;
				mul_b = omc;
			end
			ST_A2: begin
				mul_a = s0_q;
				mul_b = sd_q;
			end
			ST_A3: begin
				mul_a = c0_q;
				mul_b = sd_q;
			end
			ST_A4: begin
				mul_a = s0_q;
				mul_b = omc;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_nd    = nx_q;
		div_dd    = den;
		case (state_q)
			ST_DT: begin
				div_start = kind_q && fast;
				div_nd    = {24'b0, delta_q, 16'b0};
				div_dd    = {{40{speed_q[23]}}, speed_q};
			end
			ST_A5: begin
				div_start = 1'b1;
			end
			ST_A6: begin
				div_start = div_done;
				div_nd    = ny_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign cor_start = (state_q == ST_R3) || ((state_q == ST_CS0) && cor_done && !straight);
	assign cor_angle = (state_q == ST_CS0) ? dba_q : yaw_q;

	aoi_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p)
	);

	aoi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_nd),
		.divisor  (div_dd),
		.done     (div_done),
		.quot     (div_q)
	);

	aoi_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.angle  (cor_angle),
		.done   (cor_done),
		.sin_v  (cor_s),
		.cos_v  (cor_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rate_q      <= 24'd65536;
			gain_q      <= 24'd65536;
			east_q      <= '0;
			north_q     <= '0;
			yaw_q       <= '0;
			eff_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr) begin
				case (paddr[2])
					AOI_REG_RATE: rate_q <= pwdata[23:0];
					AOI_REG_GAIN: gain_q <= pwdata[23:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall && (state_q != ST_UPD)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_DIST;
				ST_DIST: state_q <= ST_DT;
				ST_DT:   state_q <= (kind_q && fast) ? ST_DTW : ST_SA;
				ST_DTW:  if (div_done) state_q <= ST_SA;
				ST_SA:   state_q <= ST_SB;
				ST_SB:   state_q <= ST_SC;
				ST_SC:   state_q <= ST_KQ;
				ST_KQ:   state_q <= ST_KQC;
				ST_KQC:  state_q <= ST_M1;
				ST_M1:   state_q <= ST_M2;
				ST_M2:   state_q <= ST_M3;
				ST_M3:   state_q <= ST_R1;
				ST_R1:   state_q <= ST_R2;
				ST_R2:   state_q <= ST_R3;
				ST_R3:   state_q <= ST_CS0;
				ST_CS0:  if (cor_done) state_q <= straight ? ST_L1 : ST_CS1;
				ST_L1:   state_q <= ST_L2;
				ST_L2:   state_q <= ST_L3;
				ST_L3:   state_q <= ST_UPD;
				ST_CS1:  if (cor_done) state_q <= ST_A1;
				ST_A1:   state_q <= ST_A2;
				ST_A2:   state_q <= ST_A3;
				ST_A3:   state_q <= ST_A4;
				ST_A4:   state_q <= ST_A5;
				ST_A5:   state_q <= ST_A6;
				ST_A6:   if (div_done) state_q <= ST_A7;
				ST_A7:   if (div_done) state_q <= ST_UPD;
				ST_UPD: begin
					if (out_free) begin
						east_q      <= sat_add(east_q, dx_q);
						north_q     <= sat_add(north_q, dy_q);
						yaw_q       <= yaw_q + dba_q;
						eff_q       <= eff_new_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					kind_q  <= kind;
					delta_q <= delta;
					want_q  <= desired_effort;
					speed_q <= speed;
				end
			end
			ST_DT: begin
				dist_q <= kind_q ? {8'b0, delta_q} : p[47:16];
				dt_q   <= kind_q ? '0 : {16'b0, delta_q};
			end
			ST_DTW: if (div_done) dt_q <= div_q[39:0];
			ST_SB:  pa_q <= p[40:0];
			ST_SC:  eff_new_q <= (kind_q && !fast) ? want_q : eff_slew[15:0];
			ST_KQC: kq_q <= p[41:0];
			ST_M2:  m1_q <= p[63:0];
			ST_M3:  r_q <= ((dist_q[31]) != (kq_q[41])) ? (64'd0 - m_sum) : m_sum;
			ST_R2:  pl_q <= p[63:32];
			ST_R3:  dba_q <= p[31:0] + pl_q;
			ST_CS0: begin
				if (cor_done) begin
					s0_q <= cor_s;
					c0_q <= cor_c;
				end
			end
			ST_L2: dx_q <= {{26{p[67]}}, p[67:30]};
			ST_L3: dy_q <= {{26{p[67]}}, p[67:30]};
			ST_CS1: begin
				if (cor_done) begin
					sd_q <= cor_s;
					cd_q <= cor_c;
				end
			end
			ST_A2: t_q <= p[63:0];
			ST_A3: nx_q <= t_q + p[63:0];
			ST_A4: t_q <= p[63:0];
			ST_A5: ny_q <= t_q - p[63:0];
			ST_A6: if (div_done) dx_q <= div_q;
			ST_A7: if (div_done) dy_q <= div_q;
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign x_pos        = east_q;
	assign y_pos        = north_q;
	assign heading      = yaw_q;
	assign steer_effort = eff_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_DIST)
		else $error("accepted transaction did not start the sequencer");

	a_cordic_done_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == ST_CS0 || state_q == ST_CS1))
		else $error("CORDIC finished outside a waiting state");

	a_div_done_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DTW || state_q == ST_A6 || state_q == ST_A7))
		else $error("divider finished outside a waiting state");

	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_UPD) |=> $stable(east_q) && $stable(yaw_q))
		else $error("position changed outside the update state");

endmodule
